/* rtl/qed_pkg.sv */
// shared types, constants and helpers for the triple quadrature encoder reader
package qed_pkg;

    // default sizes, handed to the top-level parameters
    localparam int NUM_ENCODERS_DEF = 3;
    localparam int COUNT_WIDTH_DEF  = 32;

    // fixed field widths
    localparam int CMD_WIDTH   = 3;
    localparam int CHAN_WIDTH  = 2;
    localparam int PIN_WIDTH   = 3;
    localparam int BTN_NUM     = 3;
    localparam int VALUE_WIDTH = 32;
    localparam int DIR_WIDTH   = 2;

    // latch bit that each button pin sets when low
    localparam logic [1:0] BTN_MAP [BTN_NUM] = '{2'd1, 2'd0, 2'd2};

    // direction codes
    localparam logic [DIR_WIDTH-1:0] DIR_NONE = 2'd0;
    localparam logic [DIR_WIDTH-1:0] DIR_UP   = 2'd1;
    localparam logic [DIR_WIDTH-1:0] DIR_DOWN = 2'd3;

    // command codes
    typedef enum logic [CMD_WIDTH-1:0] {
        CMD_SAMPLE       = 3'd0,
        CMD_UPDATE       = 3'd1,
        CMD_READ_POS     = 3'd2,
        CMD_READ_DIR     = 3'd3,
        CMD_READ_SPEED   = 3'd4,
        CMD_READ_BUTTONS = 3'd5
    } t_cmd;

    // per-channel control from the execute stage
    typedef struct packed {
        logic update;
        logic clr_dir;
        logic clr_speed;
    } t_chan_ctl;

    // encoder that feeds a reported channel: channels 0 and 1 are swapped
    function automatic int qed_src_encoder(input int chan, input int num_enc);
        int src;
        src = chan;
        if (num_enc >= 2 && chan == 0) begin
            src = 1;
        end else if (num_enc >= 2 && chan == 1) begin
            src = 0;
        end
        return src;
    endfunction

endpackage

/* rtl/qed_enc_lane.sv */
// one encoder lane: edge detect on the A line and the wrapping raw count
module qed_enc_lane
    import qed_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_accept,
    input  logic                   i_a,
    input  logic                   i_b,
    output logic [COUNT_WIDTH-1:0] o_raw
);

    logic                   r_prev_a;
    logic [COUNT_WIDTH-1:0] r_raw;
    logic [COUNT_WIDTH-1:0] n_raw;

    // count down when A equals B on an A change, up when they differ
    always_comb begin
        n_raw = r_raw;
        if (i_a != r_prev_a) begin
            if (i_a == i_b) begin
                n_raw = r_raw - {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
            end else begin
                n_raw = r_raw + {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
            end
        end
    end

    // state update on each accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_a <= 1'b0;
            r_raw    <= '0;
        end else if (i_accept) begin
            r_prev_a <= i_a;
            r_raw    <= n_raw;
        end
    end

    assign o_raw = r_raw;

endmodule

/* rtl/qed_chan_lane.sv */
// one reported channel: halved position, speed sum and last direction
module qed_chan_lane
    import qed_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [COUNT_WIDTH-1:0] i_raw,
    input  logic                   i_load_half,
    input  t_chan_ctl              i_ctl,
    output logic [COUNT_WIDTH-1:0] o_pos,
    output logic [COUNT_WIDTH-1:0] o_speed,
    output logic [DIR_WIDTH-1:0]   o_dir
);

    logic [COUNT_WIDTH-1:0] n_half;
    logic [COUNT_WIDTH-1:0] r_half;
    logic [COUNT_WIDTH-1:0] r_pos;
    logic [COUNT_WIDTH-1:0] r_speed;
    logic [DIR_WIDTH-1:0]   r_dir;
    logic [COUNT_WIDTH-1:0] delta;
    logic [DIR_WIDTH-1:0]   n_dir;

    // raw count halved, rounded toward zero
    assign n_half = {i_raw[COUNT_WIDTH-1], i_raw[COUNT_WIDTH-1:1]}
                  + {{(COUNT_WIDTH-1){1'b0}}, i_raw[COUNT_WIDTH-1] & i_raw[0]};

    // half stage register, payload only
    always_ff @(posedge i_clk) begin
        if (i_load_half) begin
            r_half <= n_half;
        end
    end

    // position change and its sign
    assign delta = r_half - r_pos;

    always_comb begin
        if (delta == '0) begin
            n_dir = DIR_NONE;
        end else if (delta[COUNT_WIDTH-1]) begin
            n_dir = DIR_DOWN;
        end else begin
            n_dir = DIR_UP;
        end
    end

    // update snapshot and clear-on-read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_speed <= '0;
            r_dir   <= DIR_NONE;
        end else begin
            if (i_ctl.update) begin
                r_pos   <= r_half;
                r_speed <= r_speed + delta;
                r_dir   <= n_dir;
            end
            if (i_ctl.clr_dir) begin
                r_dir <= DIR_NONE;
            end
            if (i_ctl.clr_speed) begin
                r_speed <= '0;
            end
        end
    end

    assign o_pos   = r_pos;
    assign o_speed = r_speed;
    assign o_dir   = r_dir;

endmodule

/* rtl/triple_quadrature_encoder_reader.sv */
// Triple quadrature encoder reader: one item per clock while the output is not stalled; the
// item goes through the sample, halving and execute stages into the output register.
// Each item samples A, B and button pins; encoder lanes count A-line edges in parallel, and
// channel lanes hold reported position, speed sum and clear-on-read direction. Reported
// channel 0 follows encoder 1 and channel 1 follows encoder 0. The button latch and snapshot
// are handled when the item is taken; a read of buttons clears both. A read of a channel
// at or above NUM_ENCODERS returns zero and clears nothing. No clearing pass after reset.
module triple_quadrature_encoder_reader
    import qed_pkg::*;
#(
    parameter int NUM_ENCODERS = NUM_ENCODERS_DEF,
    parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [CMD_WIDTH-1:0]          i_command,
    input  logic [CHAN_WIDTH-1:0]         i_channel,
    input  logic [PIN_WIDTH-1:0]          i_a_levels,
    input  logic [PIN_WIDTH-1:0]          i_b_levels,
    input  logic [PIN_WIDTH-1:0]          i_button_levels,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [VALUE_WIDTH-1:0] o_value
);

    // pipeline control
    logic r_s1_v;
    logic r_s2_v;
    logic r_out_v;
    logic out_ready;
    logic s2_go;
    logic s2_free;
    logic s1_go;
    logic s1_free;
    logic accept;

    logic [CMD_WIDTH-1:0]  r_s1_cmd;
    logic [CHAN_WIDTH-1:0] r_s1_ch;
    logic [BTN_NUM-1:0]    r_s1_btn;
    logic [CMD_WIDTH-1:0]  r_s2_cmd;
    logic [CHAN_WIDTH-1:0] r_s2_ch;
    logic [BTN_NUM-1:0]    r_s2_btn;
    logic [VALUE_WIDTH-1:0] r_out_value;
    logic [VALUE_WIDTH-1:0] n_out_value;

    // button state
    logic [BTN_NUM-1:0] r_btn_latch;
    logic [BTN_NUM-1:0] r_btn_snap;
    logic [BTN_NUM-1:0] n_btn_latch;

    // lane wiring
    logic [NUM_ENCODERS+PIN_WIDTH-1:0] a_ext;
    logic [NUM_ENCODERS+PIN_WIDTH-1:0] b_ext;
    logic [COUNT_WIDTH-1:0]  enc_raw   [NUM_ENCODERS];
    logic [COUNT_WIDTH-1:0]  ch_pos    [NUM_ENCODERS];
    logic [COUNT_WIDTH-1:0]  ch_speed  [NUM_ENCODERS];
    logic [DIR_WIDTH-1:0]    ch_dir    [NUM_ENCODERS];
    logic [VALUE_WIDTH-1:0]  pos_val   [NUM_ENCODERS];
    logic [VALUE_WIDTH-1:0]  speed_val [NUM_ENCODERS];
    t_chan_ctl               ch_ctl    [NUM_ENCODERS];

    // handshake: each stage moves when the next one is empty or moving
    assign out_ready = !r_out_v || !i_stall;
    assign s2_go     = r_s2_v && out_ready;
    assign s2_free   = !r_s2_v || out_ready;
    assign s1_go     = r_s1_v && s2_free;
    assign s1_free   = !r_s1_v || s2_free;
    assign accept    = i_valid && s1_free;
    assign o_stall   = !s1_free;
    assign o_valid   = r_out_v;
    assign o_value   = $signed(r_out_value);

    assign a_ext = {{NUM_ENCODERS{1'b0}}, i_a_levels};
    assign b_ext = {{NUM_ENCODERS{1'b0}}, i_b_levels};

    // encoder lanes
    for (genvar e = 0; e < NUM_ENCODERS; e++) begin : g_enc
        qed_enc_lane #(
            .COUNT_WIDTH(COUNT_WIDTH)
        ) u_enc (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_accept (accept),
            .i_a      (a_ext[e]),
            .i_b      (b_ext[e]),
            .o_raw    (enc_raw[e])
        );
    end

    // channel lanes with their control from the execute stage
    for (genvar c = 0; c < NUM_ENCODERS; c++) begin : g_chan
        localparam int SRC = qed_src_encoder(c, NUM_ENCODERS);
        logic [COUNT_WIDTH+VALUE_WIDTH-1:0] pos_ext;
        logic [COUNT_WIDTH+VALUE_WIDTH-1:0] speed_ext;
        logic                               sel;

        assign sel = (r_s2_ch == CHAN_WIDTH'(c)) && (c < (1 << CHAN_WIDTH));
        assign ch_ctl[c].update    = s2_go && (r_s2_cmd == CMD_UPDATE);
        assign ch_ctl[c].clr_dir   = s2_go && (r_s2_cmd == CMD_READ_DIR) && sel;
        assign ch_ctl[c].clr_speed = s2_go && (r_s2_cmd == CMD_READ_SPEED) && sel;

        qed_chan_lane #(
            .COUNT_WIDTH(COUNT_WIDTH)
        ) u_chan (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_raw       (enc_raw[SRC]),
            .i_load_half (s1_go),
            .i_ctl       (ch_ctl[c]),
            .o_pos       (ch_pos[c]),
            .o_speed     (ch_speed[c]),
            .o_dir       (ch_dir[c])
        );

        // values zero-extended or cut to the output width
        assign pos_ext      = {{VALUE_WIDTH{1'b0}}, ch_pos[c]};
        assign speed_ext    = {{VALUE_WIDTH{1'b0}}, ch_speed[c]};
        assign pos_val[c]   = pos_ext[VALUE_WIDTH-1:0];
        assign speed_val[c] = speed_ext[VALUE_WIDTH-1:0];
    end

    // button latch: each low pin sets its mapped bit
    always_comb begin
        n_btn_latch = r_btn_latch;
        for (int k = 0; k < BTN_NUM; k++) begin
            if (!i_button_levels[k]) begin
                n_btn_latch[BTN_MAP[k]] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_btn_latch <= '0;
            r_btn_snap  <= '0;
        end else if (accept) begin
            if (i_command == CMD_READ_BUTTONS) begin
                r_btn_latch <= '0;
                r_btn_snap  <= '0;
            end else begin
                r_btn_latch <= n_btn_latch;
                if (i_command == CMD_UPDATE) begin
                    r_btn_snap <= n_btn_latch;
                end
            end
        end
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (s1_free) begin
                r_s1_v <= accept;
            end
            if (s2_free) begin
                r_s2_v <= s1_go;
            end
            if (out_ready) begin
                r_out_v <= s2_go;
            end
        end
    end

    // stage payloads
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_cmd <= i_command;
            r_s1_ch  <= i_channel;
            r_s1_btn <= r_btn_snap;
        end
        if (s1_go) begin
            r_s2_cmd <= r_s1_cmd;
            r_s2_ch  <= r_s1_ch;
            r_s2_btn <= r_s1_btn;
        end
        if (s2_go) begin
            r_out_value <= n_out_value;
        end
    end

    // result merge across channel lanes
    always_comb begin
        n_out_value = '0;
        case (r_s2_cmd)
            CMD_READ_BUTTONS: begin
                n_out_value = {{(VALUE_WIDTH-BTN_NUM){1'b0}}, r_s2_btn};
            end
            CMD_READ_POS, CMD_READ_DIR, CMD_READ_SPEED: begin
                for (int c = 0; c < NUM_ENCODERS; c++) begin
                    if (c < (1 << CHAN_WIDTH) && r_s2_ch == CHAN_WIDTH'(c)) begin
                        if (r_s2_cmd == CMD_READ_POS) begin
                            n_out_value = pos_val[c];
                        end else if (r_s2_cmd == CMD_READ_SPEED) begin
                            n_out_value = speed_val[c];
                        end else begin
                            n_out_value = {{(VALUE_WIDTH-DIR_WIDTH){ch_dir[c][1]}},
                                           ch_dir[c]};
                        end
                    end
                end
            end
            default: begin
                n_out_value = '0;
            end
        endcase
    end

    // checks on the pipeline and button logic
    a_no_stall_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_v |-> !o_stall)
        else $error("input stalled with an empty output register");

    a_exec_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s2_go |=> r_out_v)
        else $error("executed item did not reach the output register");

    a_button_read_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_command == CMD_READ_BUTTONS) |=> (r_btn_latch == '0 && r_btn_snap == '0))
        else $error("button read did not clear latch and snapshot");

    a_dir_code_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ch_dir[0] != 2'b10)
        else $error("illegal direction code");

    a_s1_moves_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_v && !r_s2_v) |=> r_s2_v)
        else $error("first stage item did not advance into an empty stage");

endmodule

/* tb/sv/tb_top.sv */
// self-checking testbench for the triple quadrature encoder reader
module tb_top;
    import qed_pkg::*;

    localparam int NUM_ENC     = NUM_ENCODERS_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 8;

    // command codes with no named operation, and the channel with no encoder behind it
    localparam logic [CMD_WIDTH-1:0]  CMD_SPARE_LO = 3'd6;
    localparam logic [CMD_WIDTH-1:0]  CMD_SPARE_HI = 3'd7;
    localparam logic [CHAN_WIDTH-1:0] CHAN_NONE    = 2'd3;
    localparam logic [PIN_WIDTH-1:0]  BTN_RELEASED = 3'b111;

    typedef struct packed {
        logic [CMD_WIDTH-1:0]  command;
        logic [CHAN_WIDTH-1:0] channel;
        logic [PIN_WIDTH-1:0]  a_levels;
        logic [PIN_WIDTH-1:0]  b_levels;
        logic [PIN_WIDTH-1:0]  button_levels;
    } reader_item_t;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_valid;
    logic                          o_stall;
    logic [CMD_WIDTH-1:0]          i_command;
    logic [CHAN_WIDTH-1:0]         i_channel;
    logic [PIN_WIDTH-1:0]          i_a_levels;
    logic [PIN_WIDTH-1:0]          i_b_levels;
    logic [PIN_WIDTH-1:0]          i_button_levels;
    logic                          o_valid;
    logic                          i_stall;
    logic signed [VALUE_WIDTH-1:0] o_value;

    triple_quadrature_encoder_reader i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_command       (i_command),
        .i_channel       (i_channel),
        .i_a_levels      (i_a_levels),
        .i_b_levels      (i_b_levels),
        .i_button_levels (i_button_levels),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_value         (o_value)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predicted reader state
    logic [PIN_WIDTH-1:0]   prev_a_seen = '0;
    logic [31:0]            enc_count [NUM_ENC] = '{default: '0};
    logic [31:0]            chan_position [NUM_ENC] = '{default: '0};
    logic [31:0]            chan_speed [NUM_ENC] = '{default: '0};
    logic [DIR_WIDTH-1:0]   chan_direction [NUM_ENC] = '{default: DIR_NONE};
    logic [BTN_NUM-1:0]     button_latch_q = '0;
    logic [BTN_NUM-1:0]     button_snapshot_q = '0;

    logic [VALUE_WIDTH-1:0] expected_values [$];
    logic [VALUE_WIDTH-1:0] oldest_value;
    int                     mismatch_count = 0;
    int                     values_checked = 0;
    int                     items_sent = 0;
    int                     cycle_count = 0;
    int                     burst_left = 0;
    int                     stall_left = 0;
    int                     stall_mode = 0;
    int                     walk_phase [NUM_ENC] = '{default: 0};

    // applies one item to the predicted state and gives the value it returns
    task automatic advance_reader_state(input reader_item_t it,
                                        output logic [VALUE_WIDTH-1:0] value);
        int          src;
        int          signed_count;
        logic [31:0] new_pos;
        logic [31:0] delta;
        // pin sampling comes first
        for (int e = 0; e < NUM_ENC; e++) begin
            if (it.a_levels[e] != prev_a_seen[e]) begin
                if (it.a_levels[e] == it.b_levels[e]) begin
                    enc_count[e] = enc_count[e] - 32'd1;
                end else begin
                    enc_count[e] = enc_count[e] + 32'd1;
                end
            end
        end
        prev_a_seen = it.a_levels;
        for (int p = 0; p < BTN_NUM; p++) begin
            if (!it.button_levels[p]) begin
                button_latch_q[BTN_MAP[p]] = 1'b1;
            end
        end
        // then the command on the updated state
        value = '0;
        case (it.command)
            CMD_UPDATE: begin
                for (int c = 0; c < NUM_ENC; c++) begin
                    // reported channels 0 and 1 follow the opposite encoder
                    src = (c == 0) ? 1 : (c == 1) ? 0 : c;
                    signed_count = enc_count[src];
                    new_pos = signed_count / 2;
                    delta = new_pos - chan_position[c];
                    if (delta == '0) begin
                        chan_direction[c] = DIR_NONE;
                    end else if (delta[31]) begin
                        chan_direction[c] = DIR_DOWN;
                    end else begin
                        chan_direction[c] = DIR_UP;
                    end
                    chan_speed[c] = chan_speed[c] + delta;
                    chan_position[c] = new_pos;
                end
                button_snapshot_q = button_latch_q;
            end
            CMD_READ_POS: begin
                if (it.channel < NUM_ENC) begin
                    value = chan_position[it.channel];
                end
            end
            CMD_READ_DIR: begin
                if (it.channel < NUM_ENC) begin
                    if (chan_direction[it.channel] == DIR_DOWN) begin
                        value = '1;
                    end else begin
                        value = VALUE_WIDTH'(chan_direction[it.channel]);
                    end
                    chan_direction[it.channel] = DIR_NONE;
                end
            end
            CMD_READ_SPEED: begin
                if (it.channel < NUM_ENC) begin
                    value = chan_speed[it.channel];
                    chan_speed[it.channel] = '0;
                end
            end
            CMD_READ_BUTTONS: begin
                value = VALUE_WIDTH'(button_snapshot_q);
                button_snapshot_q = '0;
                button_latch_q = '0;
            end
            default: begin
            end
        endcase
    endtask

    function automatic reader_item_t make_item(input logic [CMD_WIDTH-1:0] cmd,
                                               input logic [CHAN_WIDTH-1:0] ch,
                                               input logic [PIN_WIDTH-1:0] a,
                                               input logic [PIN_WIDTH-1:0] b,
                                               input logic [PIN_WIDTH-1:0] btn);
        reader_item_t it;
        it.command = cmd;
        it.channel = ch;
        it.a_levels = a;
        it.b_levels = b;
        it.button_levels = btn;
        return it;
    endfunction

    // sends one item in bursts with random gaps, and records its expected value
    task automatic send_item(input reader_item_t it);
        logic [VALUE_WIDTH-1:0] expected;
        int                     gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            repeat (gap) begin
                @(negedge i_clk);
                i_valid <= 1'b0;
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_command <= it.command;
        i_channel <= it.channel;
        i_a_levels <= it.a_levels;
        i_b_levels <= it.b_levels;
        i_button_levels <= it.button_levels;
        do @(posedge i_clk); while (o_stall);
        advance_reader_state(it, expected);
        expected_values.push_back(expected);
        items_sent++;
    endtask

    // result stall pattern: runs of no stall, light, heavy and alternating
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(10, 60);
        end
        stall_left--;
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 4) == 0);
            2: i_stall <= ($urandom_range(0, 1) == 1);
            default: i_stall <= ~i_stall;
        endcase
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_values.size() == 0) begin
                $error("value: no item expected, actual %0d", o_value);
                mismatch_count++;
            end else begin
                oldest_value = expected_values.pop_front();
                if (o_value !== oldest_value) begin
                    $error("value: expected %0d, actual %0d", $signed(oldest_value), o_value);
                    mismatch_count++;
                end
                values_checked++;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // first edges, up and down counts, odd negative counts halved toward zero
    task automatic test_edge_counting();
        send_item(make_item(CMD_SAMPLE, 2'd0, 3'b111, 3'b000, BTN_RELEASED));
        send_item(make_item(CMD_SAMPLE, 2'd1, 3'b000, 3'b000, BTN_RELEASED));
        send_item(make_item(CMD_SAMPLE, 2'd2, 3'b111, 3'b111, BTN_RELEASED));
        send_item(make_item(CMD_SAMPLE, 2'd0, 3'b000, 3'b000, BTN_RELEASED));
        send_item(make_item(CMD_SAMPLE, 2'd0, 3'b111, 3'b111, BTN_RELEASED));
        send_item(make_item(CMD_UPDATE, 2'd0, 3'b111, 3'b111, BTN_RELEASED));
    endtask

    // reads on every channel, including the one with no encoder, and clear on read
    task automatic test_channel_reads();
        send_item(make_item(CMD_READ_POS, 2'd0, 3'b110, 3'b111, BTN_RELEASED));
        send_item(make_item(CMD_READ_POS, 2'd1, 3'b100, 3'b111, BTN_RELEASED));
        send_item(make_item(CMD_READ_POS, 2'd2, 3'b000, 3'b111, BTN_RELEASED));
        send_item(make_item(CMD_READ_POS, CHAN_NONE, 3'b000, 3'b111, BTN_RELEASED));
        send_item(make_item(CMD_READ_DIR, 2'd0, 3'b000, 3'b111, BTN_RELEASED));
        send_item(make_item(CMD_READ_DIR, CHAN_NONE, 3'b000, 3'b111, BTN_RELEASED));
        send_item(make_item(CMD_READ_DIR, 2'd0, 3'b000, 3'b111, BTN_RELEASED));
        send_item(make_item(CMD_READ_SPEED, 2'd1, 3'b000, 3'b111, BTN_RELEASED));
        send_item(make_item(CMD_READ_SPEED, 2'd2, 3'b000, 3'b111, BTN_RELEASED));
    endtask

    // swapped latch bits, read before update, buttons held on a read are not latched
    task automatic test_button_latch();
        send_item(make_item(CMD_SAMPLE, 2'd0, 3'b000, 3'b000, 3'b110));
        send_item(make_item(CMD_READ_BUTTONS, 2'd0, 3'b000, 3'b000, BTN_RELEASED));
        send_item(make_item(CMD_SAMPLE, 2'd0, 3'b000, 3'b000, 3'b011));
        send_item(make_item(CMD_UPDATE, 2'd0, 3'b000, 3'b000, 3'b101));
        send_item(make_item(CMD_READ_BUTTONS, 2'd0, 3'b000, 3'b000, 3'b000));
        send_item(make_item(CMD_UPDATE, 2'd0, 3'b000, 3'b000, BTN_RELEASED));
    endtask

    // spare command codes act as a plain sample
    task automatic test_spare_commands();
        send_item(make_item(CMD_SPARE_LO, CHAN_NONE, 3'b101, 3'b010, BTN_RELEASED));
        send_item(make_item(CMD_SPARE_HI, 2'd2, 3'b010, 3'b101, BTN_RELEASED));
    endtask

    // mostly clean gray-code motion with random commands, some random noise items
    task automatic test_random_motion(input int num_items);
        reader_item_t it;
        int           pick;
        int           step;
        for (int n = 0; n < num_items; n++) begin
            if ($urandom_range(0, 99) < 15) begin
                it = make_item(CMD_WIDTH'($urandom_range(0, 7)),
                               CHAN_WIDTH'($urandom_range(0, 3)),
                               PIN_WIDTH'($urandom_range(0, 7)),
                               PIN_WIDTH'($urandom_range(0, 7)),
                               PIN_WIDTH'($urandom_range(0, 7)));
            end else begin
                for (int e = 0; e < NUM_ENC; e++) begin
                    step = $urandom_range(0, 2);
                    walk_phase[e] = (walk_phase[e] + ((step == 0) ? 3 : step - 1)) % 4;
                    it.a_levels[e] = (walk_phase[e] == 1) || (walk_phase[e] == 2);
                    it.b_levels[e] = (walk_phase[e] >= 2);
                end
                pick = $urandom_range(0, 99);
                if (pick < 40) begin
                    it.command = CMD_SAMPLE;
                end else if (pick < 55) begin
                    it.command = CMD_UPDATE;
                end else if (pick < 68) begin
                    it.command = CMD_READ_POS;
                end else if (pick < 78) begin
                    it.command = CMD_READ_DIR;
                end else if (pick < 88) begin
                    it.command = CMD_READ_SPEED;
                end else if (pick < 96) begin
                    it.command = CMD_READ_BUTTONS;
                end else begin
                    it.command = $urandom_range(0, 1) ? CMD_SPARE_LO : CMD_SPARE_HI;
                end
                it.channel = CHAN_WIDTH'($urandom_range(0, 3));
                it.button_levels = ($urandom_range(0, 4) == 0) ? PIN_WIDTH'($urandom_range(0, 7))
                                                                : BTN_RELEASED;
            end
            send_item(it);
        end
    endtask

    // test sequence
    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_command = CMD_SAMPLE;
        i_channel = '0;
        i_a_levels = '0;
        i_b_levels = '0;
        i_button_levels = BTN_RELEASED;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_edge_counting();
        test_channel_reads();
        test_button_latch();
        test_spare_commands();
        test_random_motion(550);

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_values.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Covered edge counting, channel and button reads, spare codes, random motion");
        $display("Sent %0d items, checked %0d values", items_sent, values_checked);
        if (mismatch_count == 0 && expected_values.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
